// ----- design/yaz1_stream_decompressor_macros.svh -----
// Assertion macros shared by the checker files of the Yaz1 decompressor.
// Each macro expands to one labeled concurrent assertion on the clock.
`ifndef YAZ1_STREAM_DECOMPRESSOR_MACROS_SVH
`define YAZ1_STREAM_DECOMPRESSOR_MACROS_SVH
// Implication checked at every edge outside reset.
`define YAZ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define YAZ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- design/yaz1_pkg.sv -----
// Package for the Yaz1 stream decompressor: phases, sequencer states, constants.
// Used by the copy unit and the top level; depends on nothing.
`default_nettype none
package yaz1_pkg;
   localparam int HISTORY_DEPTH = 4096;
   localparam int OUT_LANES = 8;
   localparam logic [31:0] MAGIC_WORD = 32'h59617A31;
   localparam logic [7:0] LONG_LEN_BIAS = 8'h12;

   typedef enum logic [2:0] {
      PH_LEN, PH_SCAN, PH_BSIZE, PH_SKIP, PH_DECODE, PH_REF2, PH_REF3, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      SQ_IDLE, SQ_RUN, SQ_WAIT, SQ_EMIT
   } seq_type;

   // Request from the header parser to the copy unit.
   typedef struct packed {
      logic        literal;
      logic [7:0]  lit;
      logic [8:0]  len;
      logic [12:0] distance;
   } run_req_type;
endpackage
`default_nettype wire

// ----- design/yaz1_copy_unit.sv -----
// Copy unit: produces one output byte per step from a literal or the history ring,
// packs bytes into words. Depends on yaz1_pkg.
`default_nettype none
module yaz1_copy_unit #(
   parameter int HISTORY_DEPTH = yaz1_pkg::HISTORY_DEPTH,
   parameter int OUT_LANES = yaz1_pkg::OUT_LANES
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire yaz1_pkg::run_req_type req,
   input  wire logic [31:0] room,
   input  wire logic [31:0] produced,
   output logic busy,
   output logic done,
   output logic [8:0] ran,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [63:0] rsp_out_data,
   output logic [3:0] rsp_out_count,
   output logic rsp_run_last,
   output logic rsp_block_end,
   output logic rsp_bad_reference
);
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int LW = $clog2(OUT_LANES + 1);

   logic [7:0] mem [HISTORY_DEPTH];
   logic [7:0] rd_ff;
   logic [AW-1:0] wp_ff, wp_in;
   yaz1_pkg::seq_type st_ff, st_in;
   logic [8:0] left_ff, left_in, ran_ff, ran_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] room_ff, room_in;
   logic lit_ff, lit_in, bad_ff, bad_in, badb_ff, badb_in;
   logic [7:0] litv_ff, litv_in;
   logic [12:0] dist_ff, dist_in;
   logic [63:0] data_ff, data_in;
   logic [LW-1:0] n_ff, n_in;
   logic last_ff, last_in, bend_ff, bend_in, ov_ff, ov_in;
   logic [7:0] v;
   logic we;
   logic [AW-1:0] ra;

   assign busy = (st_ff != yaz1_pkg::SQ_IDLE);
   assign ran = ran_ff;
   assign rsp_valid = ov_ff;
   assign rsp_out_data = data_ff;
   assign rsp_out_count = 4'(n_ff);
   assign rsp_run_last = last_ff;
   assign rsp_block_end = bend_ff;
   assign rsp_bad_reference = badb_ff;
   assign ra = wp_ff - dist_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) mem[wp_ff] <= v;
      rd_ff <= mem[ra];
   end

   always_comb begin
      st_in = st_ff; wp_in = wp_ff; left_in = left_ff; ran_in = ran_ff;
      prod_in = prod_ff; room_in = room_ff; lit_in = lit_ff; litv_in = litv_ff;
      dist_in = dist_ff; bad_in = bad_ff; badb_in = badb_ff; data_in = data_ff;
      n_in = n_ff; last_in = last_ff; bend_in = bend_ff; ov_in = ov_ff;
      done = 1'b0; we = 1'b0; v = 8'h00;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (st_ff)
         yaz1_pkg::SQ_IDLE: begin
            if (start) begin
               lit_in = req.literal; litv_in = req.lit; dist_in = req.distance;
               left_in = ({23'd0, req.len} > room) ? room[8:0] : req.len;
               ran_in = left_in; prod_in = produced; room_in = room;
               n_in = '0; data_in = '0; bad_in = 1'b0;
               st_in = req.literal ? yaz1_pkg::SQ_RUN : yaz1_pkg::SQ_WAIT;
            end
         end
         yaz1_pkg::SQ_WAIT: st_in = yaz1_pkg::SQ_RUN;   // ring read latency
         yaz1_pkg::SQ_RUN: begin
            if (!ov_ff) begin
               if (lit_ff) v = litv_ff;
               else if ({19'd0, dist_ff} > prod_ff) begin v = 8'h00; bad_in = 1'b1; end
               else v = rd_ff;
               we = 1'b1;
               wp_in = wp_ff + 1'b1;
               prod_in = prod_ff + 1;
               room_in = room_ff - 1;
               data_in = data_ff | (64'(v) << (8 * n_ff));
               n_in = n_ff + 1'b1;
               left_in = left_ff - 1'b1;
               if (n_in == LW'(OUT_LANES) || left_in == 9'd0) begin
                  ov_in = 1'b1;
                  last_in = (left_in == 9'd0);
                  bend_in = (left_in == 9'd0) && (room_in == 32'd0);
                  badb_in = bad_in;
                  st_in = yaz1_pkg::SQ_EMIT;
               end else if (!lit_ff) st_in = yaz1_pkg::SQ_WAIT;
            end
         end
         yaz1_pkg::SQ_EMIT: begin
            if (!ov_ff) begin
               n_in = '0; data_in = '0; bad_in = 1'b0;
               if (left_ff == 9'd0) begin done = 1'b1; st_in = yaz1_pkg::SQ_IDLE; end
               else st_in = yaz1_pkg::SQ_WAIT;
            end
         end
         default: st_in = yaz1_pkg::SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= yaz1_pkg::SQ_IDLE; wp_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; wp_ff <= wp_in; ov_ff <= ov_in;
      end
      left_ff <= left_in; ran_ff <= ran_in; prod_ff <= prod_in; room_ff <= room_in;
      lit_ff <= lit_in; litv_ff <= litv_in; dist_ff <= dist_in; bad_ff <= bad_in;
      badb_ff <= badb_in; data_ff <= data_in; n_ff <= n_in; last_ff <= last_in;
      bend_ff <= bend_in;
   end
endmodule
`default_nettype wire

// ----- design/yaz1_stream_decompressor.sv -----
// Header, scan and code bytes are taken back to back.
// A literal holds the input until its word is taken; the word is built in the copy unit's
// run state and offered from its emit state. A copy holds the input until its last word is
// taken, as the single ring read port needs a wait state before each byte; receiver stall
// adds to the hold. Synchronous active-high reset returns to reading the stream length; the
// ring is not cleared, since copies only read bytes written in the same block.
`default_nettype none
module yaz1_stream_decompressor #(
   parameter int HISTORY_DEPTH = yaz1_pkg::HISTORY_DEPTH,
   parameter int OUT_LANES = yaz1_pkg::OUT_LANES
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_in_byte,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [63:0] rsp_out_data,
   output logic [3:0] rsp_out_count,
   output logic rsp_run_last,
   output logic rsp_block_end,
   output logic rsp_bad_reference
);
   yaz1_pkg::phase_type ph_ff, ph_in;
   logic [31:0] slen_ff, slen_in, cons_ff, cons_in, bsz_ff, bsz_in, prod_ff, prod_in;
   logic [23:0] win_ff, win_in;
   logic [3:0] hc_ff, hc_in, cl_ff, cl_in;
   logic [7:0] cb_ff, cb_in, r1_ff, r1_in, r2_ff, r2_in;
   logic wait_ff, wait_in;
   logic start, busy, done, acc;
   logic [8:0] ran;
   yaz1_pkg::run_req_type rq;
   logic [31:0] newprod;

   yaz1_copy_unit #(.HISTORY_DEPTH(HISTORY_DEPTH), .OUT_LANES(OUT_LANES)) u_copy (
      .clock, .reset, .start, .req(rq), .room(bsz_ff - prod_ff), .produced(prod_ff),
      .busy, .done, .ran, .rsp_valid, .rsp_ready, .rsp_out_data, .rsp_out_count,
      .rsp_run_last, .rsp_block_end, .rsp_bad_reference);

   assign req_ready = !wait_ff && !busy;
   assign acc = req_valid && req_ready;
   assign newprod = prod_ff + {23'd0, ran};

   always_comb begin
      ph_in = ph_ff; slen_in = slen_ff; cons_in = cons_ff; bsz_in = bsz_ff;
      prod_in = prod_ff; win_in = win_ff; hc_in = hc_ff; cl_in = cl_ff; cb_in = cb_ff;
      r1_in = r1_ff; r2_in = r2_ff; wait_in = wait_ff; start = 1'b0;
      rq = '{literal: 1'b1, lit: req_in_byte, len: 9'd1, distance: 13'd0};
      if (done) begin
         wait_in = 1'b0;
         prod_in = newprod;
         if (newprod >= bsz_ff) begin
            ph_in = (cons_ff >= slen_ff) ? yaz1_pkg::PH_DONE : yaz1_pkg::PH_SCAN;
            hc_in = '0; win_in = '0;
         end else begin
            ph_in = yaz1_pkg::PH_DECODE;
            cb_in = {cb_ff[6:0], 1'b0};
            cl_in = cl_ff - 1'b1;
         end
      end else if (acc && ph_ff != yaz1_pkg::PH_DONE) begin
         if (ph_ff != yaz1_pkg::PH_LEN && cons_ff != 32'hFFFFFFFF) cons_in = cons_ff + 1;
         unique case (ph_ff)
            yaz1_pkg::PH_LEN: begin
               slen_in = {slen_ff[23:0], req_in_byte};
               hc_in = hc_ff + 1'b1;
               if (hc_in >= 4'd4) begin
                  ph_in = yaz1_pkg::PH_SCAN; hc_in = '0; win_in = '0; cons_in = '0;
               end
            end
            yaz1_pkg::PH_SCAN: begin
               if (cons_ff >= slen_ff) ph_in = yaz1_pkg::PH_DONE;
               else if (hc_ff >= 4'd3 && {win_ff, req_in_byte} == yaz1_pkg::MAGIC_WORD) begin
                  ph_in = yaz1_pkg::PH_BSIZE; hc_in = '0; bsz_in = '0;
               end else begin
                  win_in = {win_ff[15:0], req_in_byte};
                  if (hc_ff < 4'd3) hc_in = hc_ff + 1'b1;
               end
            end
            yaz1_pkg::PH_BSIZE: begin
               bsz_in = {bsz_ff[23:0], req_in_byte};
               hc_in = hc_ff + 1'b1;
               if (hc_in >= 4'd4) begin ph_in = yaz1_pkg::PH_SKIP; hc_in = '0; end
            end
            yaz1_pkg::PH_SKIP: begin
               hc_in = hc_ff + 1'b1;
               if (hc_in >= 4'd8) begin
                  hc_in = '0; prod_in = '0; cb_in = '0; cl_in = '0;
                  if (bsz_ff == 32'd0) begin
                     ph_in = (cons_in >= slen_ff) ? yaz1_pkg::PH_DONE : yaz1_pkg::PH_SCAN;
                     win_in = '0;
                  end else ph_in = yaz1_pkg::PH_DECODE;
               end
            end
            yaz1_pkg::PH_DECODE: begin
               if (cl_ff == 4'd0) begin cb_in = req_in_byte; cl_in = 4'd8; end
               else if (cb_ff[7]) begin start = 1'b1; wait_in = 1'b1; end
               else begin r1_in = req_in_byte; ph_in = yaz1_pkg::PH_REF2; end
            end
            yaz1_pkg::PH_REF2: begin
               r2_in = req_in_byte;
               if (r1_ff[7:4] != 4'd0) begin
                  rq = '{literal: 1'b0, lit: 8'd0, len: {5'd0, r1_ff[7:4]} + 9'd2,
                         distance: {1'b0, r1_ff[3:0], req_in_byte} + 13'd1};
                  start = 1'b1; wait_in = 1'b1;
               end else ph_in = yaz1_pkg::PH_REF3;
            end
            yaz1_pkg::PH_REF3: begin
               rq = '{literal: 1'b0, lit: 8'd0,
                      len: {1'b0, req_in_byte} + {1'b0, yaz1_pkg::LONG_LEN_BIAS},
                      distance: {1'b0, r1_ff[3:0], r2_ff} + 13'd1};
               start = 1'b1; wait_in = 1'b1;
            end
            default: ph_in = yaz1_pkg::PH_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= yaz1_pkg::PH_LEN; slen_ff <= '0; cons_ff <= '0; bsz_ff <= '0;
         prod_ff <= '0; win_ff <= '0; hc_ff <= '0; cl_ff <= '0; cb_ff <= '0;
         r1_ff <= '0; r2_ff <= '0; wait_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; slen_ff <= slen_in; cons_ff <= cons_in; bsz_ff <= bsz_in;
         prod_ff <= prod_in; win_ff <= win_in; hc_ff <= hc_in; cl_ff <= cl_in;
         cb_ff <= cb_in; r1_ff <= r1_in; r2_ff <= r2_in; wait_ff <= wait_in;
      end
   end
endmodule
`default_nettype wire

// ----- design/yaz1_checker.sv -----
// Port-level checker for the Yaz1 decompressor, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "yaz1_stream_decompressor_macros.svh"
module yaz1_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [3:0] rsp_out_count,
   input wire logic rsp_run_last,
   input wire logic rsp_block_end
);
   `YAZ_ASSERT_IMP(a_count, clock, reset, rsp_valid, rsp_out_count != 4'd0 && rsp_out_count <= 4'd8)
   `YAZ_ASSERT_IMP(a_bend, clock, reset, rsp_valid && rsp_block_end, rsp_run_last)
   `YAZ_ASSERT_IMP(a_full, clock, reset, rsp_valid && !rsp_run_last, rsp_out_count == 4'd8)
   `YAZ_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // Input is held off while a word is waiting.
   `YAZ_ASSERT_IMP(a_stall, clock, reset, rsp_valid, !req_ready)
endmodule
bind yaz1_stream_decompressor yaz1_checker u_chk (.clock, .reset, .req_ready,
   .rsp_valid, .rsp_ready, .rsp_out_count, .rsp_run_last, .rsp_block_end);
`default_nettype wire
